@@ rtl/core/icrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrc_pkg: shared constants, types and CRC helpers
// Byte lanes, frame layout offsets and the reflected CRC-32 byte step used by
// the RoCEv2 invariant CRC engine.
// ----------------------------------------------------------------------------
package icrc_pkg;

	localparam int BEAT_BYTES       = 8;
	localparam int DATA_W           = BEAT_BYTES * 8;
	localparam int COUNT_W          = 4;
	localparam int IN_TDATA_W       = ((DATA_W + COUNT_W + 7) / 8) * 8;
	localparam int ETH_HEADER_BYTES = 14;
	localparam int OFF_W            = 16;

	localparam logic [OFF_W-1:0] OFFSET_MAX = 16'hFFFF;
	localparam logic [31:0]      CRC_POLY   = 32'hEDB88320;

	// IP-relative byte positions of interest (20-byte IP header assumed)
	localparam logic [OFF_W:0] IP_TOS       = 17'd1;
	localparam logic [OFF_W:0] IP_LEN_HI    = 17'd2;
	localparam logic [OFF_W:0] IP_LEN_LO    = 17'd3;
	localparam logic [OFF_W:0] IP_ALWAYS    = 17'd4;
	localparam logic [OFF_W:0] IP_TTL       = 17'd8;
	localparam logic [OFF_W:0] IP_CSUM_HI   = 17'd10;
	localparam logic [OFF_W:0] IP_CSUM_LO   = 17'd11;
	localparam logic [OFF_W:0] UDP_CSUM_HI  = 17'd26;
	localparam logic [OFF_W:0] UDP_CSUM_LO  = 17'd27;
	localparam logic [OFF_W:0] BTH_RESERVED = 17'd32;

	localparam logic [OFF_W-1:0] MIN_TOTAL_LEN = 16'd8;
	localparam logic [OFF_W-1:0] ICRC_BYTES    = 16'd4;

	// One beat after the lane stage: which lanes feed the CRC and with what.
	typedef struct packed {
		logic                        last;
		logic                        short_frame;
		logic [BEAT_BYTES-1:0]       fed;
		logic [BEAT_BYTES-1:0][7:0]  bytes;
	} icrc_beat_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [31:0] crc_seed();
		logic [31:0] c;
		c = 32'hFFFFFFFF;
		for (int i = 0; i < 8; i++) begin
			c = crc_feed(c, 8'hFF);
		end
		return c;
	endfunction

	localparam logic [31:0] CRC_INIT = crc_seed();

endpackage
`default_nettype wire

@@ rtl/core/icrc_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrc_lane: per-byte classifier
// Decides whether one byte of a beat is covered by the ICRC, masks variant
// fields to all ones and flags the IP total length bytes.
// ----------------------------------------------------------------------------
module icrc_lane (
	input  wire logic [icrc_pkg::OFF_W:0]   lane_offset,
	input  wire logic                       in_use,
	input  wire logic [7:0]                 data_byte,
	input  wire logic [icrc_pkg::OFF_W-1:0] covered_end,
	output logic                            fed,
	output logic [7:0]                      fed_byte,
	output logic                            len_hi,
	output logic                            len_lo
);

	logic                      taken;
	logic [icrc_pkg::OFF_W:0]  ip;
	logic                      variant;

	always_comb begin
		// A byte at or past the saturated offset is dropped entirely.
		taken = in_use
			&& (lane_offset < {1'b0, icrc_pkg::OFFSET_MAX})
			&& (lane_offset >= (icrc_pkg::OFF_W + 1)'(icrc_pkg::ETH_HEADER_BYTES));
		ip = lane_offset - (icrc_pkg::OFF_W + 1)'(icrc_pkg::ETH_HEADER_BYTES);
		variant = (ip == icrc_pkg::IP_TOS) || (ip == icrc_pkg::IP_TTL)
			|| (ip == icrc_pkg::IP_CSUM_HI) || (ip == icrc_pkg::IP_CSUM_LO)
			|| (ip == icrc_pkg::UDP_CSUM_HI) || (ip == icrc_pkg::UDP_CSUM_LO)
			|| (ip == icrc_pkg::BTH_RESERVED);
		fed = taken && ((ip < icrc_pkg::IP_ALWAYS) || (ip < {1'b0, covered_end}));
		fed_byte = variant ? 8'hFF : data_byte;
		len_hi = taken && (ip == icrc_pkg::IP_LEN_HI);
		len_lo = taken && (ip == icrc_pkg::IP_LEN_LO);
	end

endmodule
`default_nettype wire

@@ rtl/core/icrc_track.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrc_track: frame tracker and lane stage
// Keeps the frame offset and the covered length, runs one classifier per byte
// lane and registers the classified beat for the CRC merge stage.
// ----------------------------------------------------------------------------
module icrc_track (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [icrc_pkg::DATA_W-1:0]    beat_data,
	input  wire logic [icrc_pkg::COUNT_W-1:0]   byte_count,
	input  wire logic                           last_beat,
	input  wire logic                           advance,
	output logic                                valid_s1,
	output icrc_pkg::icrc_beat_t                beat_s1
);

	localparam int NB = icrc_pkg::BEAT_BYTES;
	localparam int OW = icrc_pkg::OFF_W;

	logic [OW-1:0]                   frame_offset_q;
	logic [OW-1:0]                   covered_end_q;
	logic [icrc_pkg::COUNT_W-1:0]    n;
	logic [NB-1:0]                   lane_fed;
	logic [NB-1:0][7:0]              lane_byte;
	logic [NB-1:0]                   lane_hi;
	logic [NB-1:0]                   lane_lo;
	logic [7:0]                      len_hi_byte;
	logic [7:0]                      len_lo_byte;
	logic [OW-1:0]                   ip_length;
	logic [OW-1:0]                   covered_new;
	logic [OW:0]                     offset_sum;
	logic [OW-1:0]                   offset_new;
	logic [OW-1:0]                   seen;
	logic                            is_short;
	logic                            accept;

	assign n = (byte_count > icrc_pkg::COUNT_W'(NB)) ? icrc_pkg::COUNT_W'(NB) : byte_count;

	for (genvar i = 0; i < NB; i++) begin : g_lane
		icrc_lane u_lane (
			.lane_offset (({1'b0, frame_offset_q} + (OW + 1)'(i))),
			.in_use      ((icrc_pkg::COUNT_W'(i) < n)),
			.data_byte   (beat_data[8*i +: 8]),
			.covered_end (covered_new),
			.fed         (lane_fed[i]),
			.fed_byte    (lane_byte[i]),
			.len_hi      (lane_hi[i]),
			.len_lo      (lane_lo[i])
		);
	end

	always_comb begin
		len_hi_byte = covered_end_q[OW-1:8];
		len_lo_byte = '0;
		for (int i = 0; i < NB; i++) begin
			if (lane_hi[i]) begin
				len_hi_byte = beat_data[8*i +: 8];
			end
			if (lane_lo[i]) begin
				len_lo_byte = beat_data[8*i +: 8];
			end
		end
		ip_length = {len_hi_byte, len_lo_byte};
		// Only the lanes past the low length byte look at the new value, so a
		// beat that holds both length bytes is handled in the same cycle.
		if (|lane_lo) begin
			covered_new = (ip_length >= icrc_pkg::MIN_TOTAL_LEN)
				? (ip_length - icrc_pkg::ICRC_BYTES) : icrc_pkg::ICRC_BYTES;
		end else if (|lane_hi) begin
			covered_new = {len_hi_byte, 8'h00};
		end else begin
			covered_new = covered_end_q;
		end

		offset_sum = {1'b0, frame_offset_q} + (OW + 1)'(n);
		offset_new = (offset_sum >= {1'b0, icrc_pkg::OFFSET_MAX})
			? icrc_pkg::OFFSET_MAX : offset_sum[OW-1:0];
		seen = (offset_new > OW'(icrc_pkg::ETH_HEADER_BYTES))
			? (offset_new - OW'(icrc_pkg::ETH_HEADER_BYTES)) : '0;
		is_short = (seen < icrc_pkg::ICRC_BYTES) || (seen < covered_new);
	end

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_offset_q <= '0;
			covered_end_q  <= '0;
			valid_s1       <= 1'b0;
			beat_s1        <= '0;
		end else begin
			if (accept) begin
				if (last_beat) begin
					frame_offset_q <= '0;
					covered_end_q  <= '0;
				end else begin
					frame_offset_q <= offset_new;
					covered_end_q  <= covered_new;
				end
				beat_s1.last        <= last_beat;
				beat_s1.short_frame <= is_short;
				beat_s1.fed         <= lane_fed;
				beat_s1.bytes       <= lane_byte;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/icrc_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icrc_merge: CRC merge and result register
// Folds the fed lanes of one beat into the running CRC and holds the final,
// inverted CRC until the downstream side takes it.
// ----------------------------------------------------------------------------
module icrc_merge (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid_s1,
	input  wire icrc_pkg::icrc_beat_t  beat_s1,
	output logic                       advance,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [31:0]                icrc,
	output logic                       short_frame
);

	logic [31:0] crc_q;
	logic [31:0] crc_next;
	logic        out_valid_q;
	logic [31:0] icrc_q;
	logic        short_q;

	// Fed lanes always form one contiguous run, so a masked chain suffices.
	always_comb begin
		crc_next = crc_q;
		for (int i = 0; i < icrc_pkg::BEAT_BYTES; i++) begin
			if (beat_s1.fed[i]) begin
				crc_next = icrc_pkg::crc_feed(crc_next, beat_s1.bytes[i]);
			end
		end
	end

	assign advance = valid_s1 && (!beat_s1.last || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= icrc_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				crc_q <= beat_s1.last ? icrc_pkg::CRC_INIT : crc_next;
			end
			if (advance && beat_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.last) begin
			icrc_q  <= ~crc_next;
			short_q <= beat_s1.short_frame;
		end
	end

	assign out_valid   = out_valid_q;
	assign icrc        = icrc_q;
	assign short_frame = short_q;

endmodule
`default_nettype wire

@@ rtl/core/rocev2_icrc_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rocev2_icrc_engine: RoCEv2 invariant CRC over an Ethernet frame
// Eight byte lanes classify each beat, a merge stage folds them into the
// reflected CRC-32 and one result per frame leaves on the last beat.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                          tuser         tlast
//  s_*       in         [63:0] bytes, [67:64] count    -             last_beat
//  m_*       out        [31:0] icrc                    short_frame   -
//
// A beat of up to eight bytes is taken every cycle unless the input stalls;
// the last beat passes the lane stage, then the CRC merge, to the result.
// The rate is set by the merge stage, which folds all eight lanes into the
// running CRC at once. Reset clears the frame state and the pipeline.
// The input stalls only while a finished result waits and another last
// beat is ready to replace it.
// ----------------------------------------------------------------------------
module rocev2_icrc_engine (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [icrc_pkg::IN_TDATA_W-1:0]  s_tdata,  // beat_data, byte_count, zero pad
	input  wire logic                             s_tlast,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [31:0]                           m_tdata,  // icrc
	output logic                                  m_tuser   // short_frame
);

	logic                  valid_s1;
	icrc_pkg::icrc_beat_t  beat_s1;
	logic                  advance;

	icrc_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.beat_data  (s_tdata[icrc_pkg::DATA_W-1:0]),
		.byte_count (s_tdata[icrc_pkg::DATA_W +: icrc_pkg::COUNT_W]),
		.last_beat  (s_tlast),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.beat_s1    (beat_s1)
	);

	icrc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.beat_s1     (beat_s1),
		.advance     (advance),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.icrc        (m_tdata),
		.short_frame (m_tuser)
	);

	// The input side only ever waits on a held result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
	else $error("input stalled without output back-pressure");

	// Covered bytes of a beat form a single contiguous run of lanes.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($countones(beat_s1.fed ^ (beat_s1.fed >> 1)) <= 2))
	else $error("covered lanes are not contiguous");

	// A last beat leaving the lane stage always yields a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && beat_s1.last) |=> m_tvalid)
	else $error("last beat merged without a result");

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rocev2_icrc_engine
// Ethernet frames are cut into beats, full or of random size, and fed into the
// input stream with random gaps, while the output side stalls at random.
// A bit-level model of the invariant CRC predicts one result per frame, and
// each result is checked against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int RANDOM_BEATS = 1350;
	localparam int ETH_BYTES    = icrc_pkg::ETH_HEADER_BYTES;
	localparam int LEN_HI_POS   = ETH_BYTES + 2;

	typedef enum {SPLIT_MIXED, SPLIT_FULL, SPLIT_WIDE} split_t;
	typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
		int          gap;
		bit          drain;
	} beat_req_t;

	typedef struct packed {
		logic [31:0] icrc;
		logic        short_frame;
	} crc_result_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [icrc_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                             s_tlast  = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [31:0]                      m_tdata;
	logic                             m_tuser;

	rocev2_icrc_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	beat_req_t   pending_reqs[$];
	crc_result_t icrc_due[$];
	logic [7:0]  frame_bytes[$];
	beat_req_t   cur_req;
	bit          tx_busy  = 1'b0;
	bit          tx_armed = 1'b0;
	int          tx_wait  = 0;
	int          rx_wait  = 0;
	int          beats_made = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          cycles = 0;

	// Predicted frame state
	logic [31:0] crc_run;
	int          off_run;
	int          cov_end;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] crc32_octet(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in;
		// One data bit at a time, least significant first.
		for (int k = 0; k < 8; k++) begin
			c = {1'b0, c[31:1]} ^ ({32{c[0] ^ b[k]}} & icrc_pkg::CRC_POLY);
		end
		return c;
	endfunction

	function automatic void icrc_restart();
		logic [31:0] c;
		c = 32'hFFFF_FFFF;
		for (int i = 0; i < 8; i++) begin
			c = crc32_octet(c, 8'hFF);
		end
		crc_run = c;
		off_run = 0;
		cov_end = 0;
	endfunction

	function automatic bit is_variant_octet(input int ip);
		return ip == int'(icrc_pkg::IP_TOS) || ip == int'(icrc_pkg::IP_TTL) ||
			ip == int'(icrc_pkg::IP_CSUM_HI) || ip == int'(icrc_pkg::IP_CSUM_LO) ||
			ip == int'(icrc_pkg::UDP_CSUM_HI) || ip == int'(icrc_pkg::UDP_CSUM_LO) ||
			ip == int'(icrc_pkg::BTH_RESERVED);
	endfunction

	function automatic void icrc_take_octet(input logic [7:0] b_in);
		logic [7:0] b;
		int         ofs;
		int         ip;
		int         tl;
		b = b_in;
		// Once the offset has saturated, further bytes are dropped altogether.
		if (off_run >= int'(icrc_pkg::OFFSET_MAX))
			return;
		ofs = off_run;
		off_run = ofs + 1;
		if (ofs < ETH_BYTES)
			return;
		ip = ofs - ETH_BYTES;
		if (ip == int'(icrc_pkg::IP_LEN_HI))
			cov_end = int'(b) << 8;
		if (ip == int'(icrc_pkg::IP_LEN_LO)) begin
			tl = (cov_end & 'hFF00) | int'(b);
			cov_end = (tl >= int'(icrc_pkg::MIN_TOTAL_LEN)) ? tl - int'(icrc_pkg::ICRC_BYTES)
				: int'(icrc_pkg::ICRC_BYTES);
		end
		if (ip < int'(icrc_pkg::IP_ALWAYS) || ip < cov_end) begin
			if (is_variant_octet(ip))
				b = 8'hFF;
			crc_run = crc32_octet(crc_run, b);
		end
	endfunction

	function automatic void icrc_absorb(input beat_req_t r);
		int          n;
		int          seen;
		crc_result_t res;
		n = int'(r.cnt);
		if (n > icrc_pkg::BEAT_BYTES)
			n = icrc_pkg::BEAT_BYTES;
		for (int i = 0; i < n; i++) begin
			icrc_take_octet(r.data[8*i +: 8]);
		end
		if (r.last) begin
			seen = (off_run > ETH_BYTES) ? off_run - ETH_BYTES : 0;
			res.icrc = ~crc_run;
			res.short_frame = (seen < int'(icrc_pkg::IP_ALWAYS)) || (seen < cov_end);
			icrc_due.push_back(res);
			icrc_restart();
		end
	endfunction

	function automatic logic [7:0] fill_octet(input fill_t fill);
		case (fill)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default:   return 8'($urandom);
		endcase
	endfunction

	task automatic make_frame(input int nbytes, input int len_field, input fill_t fill);
		frame_bytes.delete();
		for (int i = 0; i < nbytes; i++) begin
			frame_bytes.push_back(fill_octet(fill));
		end
		if (len_field >= 0 && nbytes > LEN_HI_POS)
			frame_bytes[LEN_HI_POS] = 8'(len_field >> 8);
		if (len_field >= 0 && nbytes > LEN_HI_POS + 1)
			frame_bytes[LEN_HI_POS + 1] = 8'(len_field);
	endtask

	// Cuts the current frame into requests. Lanes above the byte count carry
	// filler so that the block is seen to ignore them.
	task automatic emit_frame(input split_t style, input fill_t fill, input bit calm,
			input bit drain, input bit empty_tail);
		int        idx;
		int        take;
		int        total;
		bit        first;
		beat_req_t br;
		total = frame_bytes.size();
		idx = 0;
		first = 1'b1;
		do begin
			take = (total - idx > 8) ? 8 : total - idx;
			br.cnt = 4'(take);
			if (style == SPLIT_MIXED) begin
				if (take > 0)
					take = $urandom_range(1, take);
				br.cnt = 4'(take);
				if ($urandom_range(0, 19) == 0) begin
					take = 0;
					br.cnt = 4'd0;
				end else if (take == 8 && $urandom_range(0, 7) == 0) begin
					br.cnt = 4'($urandom_range(9, 15));
				end
			end else if (style == SPLIT_WIDE && take == 8) begin
				br.cnt = 4'd15;
			end
			for (int i = 0; i < 8; i++) begin
				br.data[8*i +: 8] = (i < take) ? frame_bytes[idx + i] : fill_octet(fill);
			end
			idx += take;
			br.last = (idx == total) && !empty_tail;
			br.gap = calm ? 0 : $urandom_range(0, 9);
			br.drain = drain && first;
			first = 1'b0;
			pending_reqs.push_back(br);
			beats_made++;
		end while (idx < total);
		if (empty_tail) begin
			br.data = {fill_octet(fill), fill_octet(fill), fill_octet(fill), fill_octet(fill),
				fill_octet(fill), fill_octet(fill), fill_octet(fill), fill_octet(fill)};
			br.cnt = 4'd0;
			br.last = 1'b1;
			br.gap = calm ? 0 : $urandom_range(0, 9);
			br.drain = 1'b0;
			pending_reqs.push_back(br);
			beats_made++;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	// Request driver
	always @(posedge clk) begin : drive
		logic [icrc_pkg::IN_TDATA_W-1:0] word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_busy = 1'b0;
			tx_armed = 1'b0;
			icrc_restart();
		end else begin
			if (s_tvalid && s_tready) begin
				icrc_absorb(cur_req);
				tx_busy = 1'b0;
			end
			if (!tx_busy && pending_reqs.size() > 0) begin
				if (!tx_armed) begin
					tx_wait = pending_reqs[0].gap;
					tx_armed = 1'b1;
				end
				if (tx_wait > 0) begin
					tx_wait--;
				end else if (!pending_reqs[0].drain || icrc_due.size() == 0) begin
					cur_req = pending_reqs.pop_front();
					tx_armed = 1'b0;
					tx_busy = 1'b1;
					word = '0;
					word[icrc_pkg::DATA_W-1:0] = cur_req.data;
					word[icrc_pkg::DATA_W +: icrc_pkg::COUNT_W] = cur_req.cnt;
					s_tdata <= word;
					s_tlast <= cur_req.last;
				end
			end
			s_tvalid <= tx_busy;
		end
	end

	// Result monitor; every fourth block of sixteen results sees no stalls.
	always @(posedge clk) begin : watch
		crc_result_t want;
		logic        rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = $urandom_range(0, 9);
		end else begin
			rdy = m_tready;
			if (m_tvalid && m_tready) begin
				if (icrc_due.size() == 0) begin
					flag_mismatch("result with none outstanding, icrc", 32'hx, m_tdata);
				end else begin
					want = icrc_due.pop_front();
					if (m_tdata !== want.icrc)
						flag_mismatch("icrc", want.icrc, m_tdata);
					if (m_tuser !== want.short_frame)
						flag_mismatch("short_frame", 32'(want.short_frame), 32'(m_tuser));
				end
				results_seen++;
				rx_wait = ((results_seen / 16) % 4 == 3) ? 0 : $urandom_range(0, 9);
				rdy = (rx_wait == 0);
			end else if (!m_tready) begin
				if (rx_wait > 0)
					rx_wait--;
				rdy = (rx_wait == 0);
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("rocev2_icrc_engine: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int pick;
		int tl;
		int nb;
		// Frame ends before any byte arrives.
		make_frame(0, -1, FILL_RANDOM);
		emit_frame(SPLIT_FULL, FILL_RANDOM, 1'b0, 1'b0, 1'b0);
		// Frame ends inside the Ethernet header.
		make_frame(10, -1, FILL_ONES);
		emit_frame(SPLIT_FULL, FILL_ONES, 1'b0, 1'b0, 1'b0);
		// Only the high length byte has been seen.
		make_frame(17, -1, FILL_RANDOM);
		emit_frame(SPLIT_FULL, FILL_RANDOM, 1'b1, 1'b0, 1'b0);
		// Zero total length, all-zero beats, the full ones with oversized byte counts.
		make_frame(22, 0, FILL_ZERO);
		emit_frame(SPLIT_WIDE, FILL_ZERO, 1'b0, 1'b0, 1'b0);
		// Total lengths either side of the smallest that is taken as given.
		make_frame(30, 7, FILL_RANDOM);
		emit_frame(SPLIT_MIXED, FILL_RANDOM, 1'b0, 1'b0, 1'b0);
		make_frame(22, 8, FILL_RANDOM);
		emit_frame(SPLIT_FULL, FILL_RANDOM, 1'b0, 1'b0, 1'b1);
		// All-ones frame; the sender first lets every result drain.
		make_frame(54, 40, FILL_ONES);
		emit_frame(SPLIT_FULL, FILL_ONES, 1'b0, 1'b1, 1'b0);
		// Longest total length, in a frame that ends far short of it.
		make_frame(120, 16'hFFFF, FILL_RANDOM);
		emit_frame(SPLIT_FULL, FILL_RANDOM, 1'b1, 1'b0, 1'b0);

		while (beats_made < RANDOM_BEATS) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				tl = ($urandom_range(0, 9) == 0) ? $urandom_range(121, 600)
					: $urandom_range(20, 120);
				nb = ETH_BYTES + tl + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
			end else if (pick < 80) begin
				tl = $urandom_range(20, 200);
				nb = $urandom_range(0, ETH_BYTES + tl - 1);
			end else if (pick < 92) begin
				tl = $urandom_range(0, 9);
				nb = $urandom_range(ETH_BYTES, 40);
			end else begin
				tl = $urandom_range(0, 65535);
				nb = $urandom_range(0, 100);
			end
			make_frame(nb, tl, FILL_RANDOM);
			emit_frame(SPLIT_MIXED, FILL_RANDOM, $urandom_range(0, 4) == 0,
				$urandom_range(0, 24) == 0, $urandom_range(0, 15) == 0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (pending_reqs.size() != 0 || tx_busy || icrc_due.size() != 0)
			@(negedge clk);
		// Two-stage pipeline; keep the clock running for anything stray.
		repeat (10) @(posedge clk);
		if (mismatches == 0 && icrc_due.size() == 0)
			$display("rocev2_icrc_engine: match");
		else
			$display("rocev2_icrc_engine: mismatch");
		$finish;
	end

endmodule

@@ rocev2_icrc_engine.f @@
rtl/core/icrc_pkg.sv
rtl/core/icrc_lane.sv
rtl/core/icrc_track.sv
rtl/core/icrc_merge.sv
rtl/core/rocev2_icrc_engine.sv
test/testbench.sv
